/* hdl/stt_pkg.sv */
// shared types, codes and character tables for the source text tokenizer
package stt_pkg;

  localparam int KW_CHARS = 9;
  localparam int FRONT_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [2:0] CLS_KEYWORD  = 3'd0;
  localparam logic [2:0] CLS_RESERVED = 3'd1;
  localparam logic [2:0] CLS_IDENT    = 3'd2;
  localparam logic [2:0] CLS_NUMBER   = 3'd3;
  localparam logic [2:0] CLS_OPER     = 3'd4;
  localparam logic [2:0] CLS_DELIM    = 3'd5;
  localparam logic [2:0] CLS_COMMENT  = 3'd6;
  localparam logic [2:0] CLS_ERROR    = 3'd7;

  typedef enum logic [3:0] {
    K_SPACE, K_ALPHA, K_DIGIT, K_UNDER, K_HASH, K_QUOTE, K_PAIR, K_DELIM, K_OTHER
  } char_kind_t;

  typedef enum logic [2:0] {S_IDLE, S_WORD, S_NUMBER, S_LINE, S_BLOCK} scan_mode_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] text_char;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_class;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ch;
    char_kind_t kind;
  } cchar_t;

  typedef struct packed {
    logic   is_end;
    cchar_t c;
  } fitem_t;

  // words left-justified in 9 bytes
  localparam logic [71:0] RSV_WORDS [7] = '{
    {"pipeline", 8'h0}, {"using", 32'h0}, {"extension"}, {"trait", 32'h0},
    {"assert", 24'h0}, {"module", 24'h0}, {"delegate", 8'h0}
  };

  localparam logic [71:0] KEY_WORDS [22] = '{
    {"int", 48'h0}, {"float", 32'h0}, {"bool", 40'h0}, {"str", 48'h0},
    {"char", 40'h0}, {"if", 56'h0}, {"else", 40'h0}, {"return", 24'h0},
    {"while", 32'h0}, {"elif", 40'h0}, {"for", 48'h0}, {"continue", 8'h0},
    {"break", 32'h0}, {"const", 32'h0}, {"def", 48'h0}, {"true", 40'h0},
    {"false", 32'h0}, {"print", 32'h0}, {"input", 32'h0}, {"with", 40'h0},
    {"chance", 24'h0}, {"value", 32'h0}
  };

  function automatic char_kind_t classify(logic [7:0] c);
    char_kind_t k;
    priority if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) k = K_SPACE;
    else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) k = K_ALPHA;
    else if (c >= "0" && c <= "9") k = K_DIGIT;
    else if (c == "_") k = K_UNDER;
    else if (c == "#") k = K_HASH;
    else if (c == 8'h22) k = K_QUOTE;
    else if (c == "~" || c == "+" || c == "-" || c == "=" || c == "*" || c == "/" ||
             c == "%" || c == "^" || c == ">" || c == "<" || c == "!" || c == "&" ||
             c == "|") k = K_PAIR;
    else if (c == ";" || c == "," || c == "(" || c == ")" || c == "{" || c == "}" ||
             c == "[" || c == "]" || c == "." || c == 8'h27) k = K_DELIM;
    else k = K_OTHER;
    return k;
  endfunction

  function automatic logic pairs_with(logic [7:0] c, logic [7:0] d);
    logic r;
    if (c == "+" || c == "-") r = (d == c) || (d == "=") || (d >= "0" && d <= "9");
    else if (c == "&" || c == "|") r = (d == c);
    else r = (d == "=");
    return r;
  endfunction

  function automatic logic [2:0] word_class(logic [71:0] key, logic ok);
    logic rsv;
    logic kw;
    rsv = 1'b0;
    kw = 1'b0;
    for (int i = 0; i < 7; i++) rsv = rsv | (key == RSV_WORDS[i]);
    for (int i = 0; i < 22; i++) kw = kw | (key == KEY_WORDS[i]);
    if (ok && rsv) return CLS_RESERVED;
    if (ok && kw) return CLS_KEYWORD;
    return CLS_IDENT;
  endfunction

endpackage

/* hdl/source_text_tokenizer.sv */
// top level of the source text tokenizer
//  channel   handshake          payload
//  item      push / full        mode, text_char
//  token     empty / pop        token_class, token_start, token_length, last_of_run
// one scanner step per cycle while work is waiting and the result queue has room;
// a character closing a run or after two waiting quotes waits for their tokens.
// the scanner step loop in stt_back sets the rate; a two-entry input queue
// and a four-entry result queue absorb stalls on either side.
// synchronous reset returns to position zero with no pending token; no sweep.
module source_text_tokenizer #(
  parameter int WORD_COMPARE_CHARS = 9,
  parameter int POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::in_item_t  item,
  input  logic               push,
  output logic               full,
  output stt_pkg::out_item_t token,
  output logic               empty,
  input  logic               pop
);
  stt_pkg::fitem_t    head;
  logic               avail, take, res_wr, qfull;
  stt_pkg::out_item_t res;

  stt_front u_front (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .head(head), .avail(avail), .take(take)
  );

  stt_back #(
    .WORD_COMPARE_CHARS(WORD_COMPARE_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .head(head), .avail(avail), .take(take),
    .res(res), .res_wr(res_wr), .qfull(qfull)
  );

  stt_outq u_outq (
    .clk(clk), .rst(rst), .wdata(res), .wr(res_wr), .qfull(qfull),
    .token(token), .empty(empty), .pop(pop)
  );
endmodule

/* hdl/stt_front.sv */
// input queue that classifies each character on entry
module stt_front (
  input  logic              clk,
  input  logic              rst,
  input  stt_pkg::in_item_t item,
  input  logic              push,
  output logic              full,
  output stt_pkg::fitem_t   head,
  output logic              avail,
  input  logic              take
);
  stt_pkg::fitem_t mem [stt_pkg::FRONT_DEPTH];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign full  = (count == 2'(stt_pkg::FRONT_DEPTH));
  assign avail = (count != 2'd0);
  assign do_wr = push && !full;
  assign do_rd = take && avail;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr].is_end <= item.mode;
      mem[wptr].c.ch   <= item.text_char;
      mem[wptr].c.kind <= stt_pkg::classify(item.text_char);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule

/* hdl/stt_outq.sv */
// result queue in front of the token ports
module stt_outq (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::out_item_t wdata,
  input  logic               wr,
  output logic               qfull,
  output stt_pkg::out_item_t token,
  output logic               empty,
  input  logic               pop
);
  stt_pkg::out_item_t mem [stt_pkg::OUTQ_DEPTH];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       do_wr, do_rd;

  assign qfull = (count == 3'(stt_pkg::OUTQ_DEPTH));
  assign empty = (count == 3'd0);
  assign do_wr = wr && !qfull;
  assign do_rd = pop && !empty;
  assign token = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (do_wr) wptr <= wptr + 2'd1;
      if (do_rd) rptr <= rptr + 2'd1;
      count <= count + 3'(do_wr) - 3'(do_rd);
    end
  end
endmodule

/* hdl/stt_back.sv */
// scanning engine: one step per cycle unless stalled, output via a hold register
module stt_back #(
  parameter int WORD_COMPARE_CHARS = 9,
  parameter int POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::fitem_t    head,
  input  logic               avail,
  output logic               take,
  output stt_pkg::out_item_t res,
  output logic               res_wr,
  input  logic               qfull
);
  localparam int IW = (WORD_COMPARE_CHARS > 1) ? $clog2(WORD_COMPARE_CHARS) : 1;
  localparam int P = POSITION_BITS;

  stt_pkg::scan_mode_t mode, mode_next;
  logic [7:0]     word [WORD_COMPARE_CHARS];
  logic           too_long, too_long_next;
  logic [P-1:0]   run_start, run_start_next;
  logic [15:0]    run_length, run_length_next;
  logic [P-1:0]   text_pos;
  logic [1:0]     qrun, qrun_next;
  stt_pkg::cchar_t la [2];
  logic [1:0]     la_cnt;
  logic           active;
  stt_pkg::cchar_t w [3];
  logic [1:0]     wn;
  logic           wend;
  logic [P-1:0]   wpos;
  stt_pkg::out_item_t hold;
  logic           hold_v;

  stt_pkg::cchar_t v [3];
  stt_pkg::cchar_t va [3];
  logic [1:0]     vn, vn_after, cons;
  logic           vend, brk, emit, done, go;
  logic [P-1:0]   vpos, epos;
  logic [2:0]     ecls, fin_cls;
  logic [15:0]    elen, grown;
  logic [71:0]    key;
  logic           wr_en;
  logic [IW-1:0]  wr_idx;
  logic [7:0]     wr_data;
  logic [1:0]     qinc;

  // operand view: work in flight, or lookahead plus the new character
  always_comb begin
    if (active) begin
      v = w;
      vn = wn;
      vend = wend;
      vpos = wpos;
    end else begin
      v[0] = (la_cnt != 2'd0) ? la[0] : head.c;
      v[1] = (la_cnt == 2'd2) ? la[1] : head.c;
      v[2] = head.c;
      vn = la_cnt + 2'(!head.is_end);
      vend = head.is_end;
      vpos = text_pos - P'(la_cnt);
    end
  end

  always_comb begin
    for (int k = 0; k < stt_pkg::KW_CHARS; k++)
      key[71-8*k -: 8] = (16'(k) < run_length) ? word[k] : 8'h00;
    priority case (mode)
      stt_pkg::S_WORD: fin_cls = stt_pkg::word_class(key,
                  !too_long && run_length <= 16'(stt_pkg::KW_CHARS));
      stt_pkg::S_NUMBER: fin_cls = stt_pkg::CLS_NUMBER;
      default: fin_cls = stt_pkg::CLS_COMMENT;
    endcase
    grown = (run_length == 16'hFFFF) ? run_length : run_length + 16'd1;
    qinc = qrun + 2'd1;
  end

  // next state of the scanner
  always_comb begin
    mode_next = mode;
    too_long_next = too_long;
    run_start_next = run_start;
    run_length_next = run_length;
    qrun_next = qrun;
    cons = 2'd0;
    brk = 1'b0;
    emit = 1'b0;
    ecls = fin_cls;
    epos = vpos;
    elen = 16'd1;
    wr_en = 1'b0;
    wr_idx = run_length[IW-1:0];
    wr_data = v[0].ch;
    if (vn == 2'd0) begin
      if (vend && mode != stt_pkg::S_IDLE) begin
        emit = 1'b1;
        epos = run_start;
        elen = run_length;
        mode_next = stt_pkg::S_IDLE;
      end
    end else begin
      unique case (mode)
        stt_pkg::S_WORD: begin
          if (v[0].kind != stt_pkg::K_ALPHA && v[0].kind != stt_pkg::K_DIGIT &&
              v[0].kind != stt_pkg::K_UNDER) begin
            emit = 1'b1;
            epos = run_start;
            elen = run_length;
            mode_next = stt_pkg::S_IDLE;
          end else begin
            if (32'(run_length) < WORD_COMPARE_CHARS) wr_en = 1'b1;
            else too_long_next = 1'b1;
            run_length_next = grown;
            cons = 2'd1;
          end
        end
        stt_pkg::S_NUMBER: begin
          if (v[0].kind != stt_pkg::K_DIGIT) begin
            emit = 1'b1;
            epos = run_start;
            elen = run_length;
            mode_next = stt_pkg::S_IDLE;
          end else begin
            run_length_next = grown;
            cons = 2'd1;
          end
        end
        stt_pkg::S_LINE: begin
          if (v[0].ch == 8'h0a) begin
            emit = 1'b1;
            epos = run_start;
            elen = run_length;
            mode_next = stt_pkg::S_IDLE;
          end else begin
            run_length_next = grown;
            cons = 2'd1;
          end
        end
        stt_pkg::S_BLOCK: begin
          run_length_next = grown;
          cons = 2'd1;
          qrun_next = (v[0].kind == stt_pkg::K_QUOTE) ? qinc : 2'd0;
          if (v[0].kind == stt_pkg::K_QUOTE && qinc == 2'd3) begin
            emit = 1'b1;
            epos = run_start;
            elen = grown;
            mode_next = stt_pkg::S_IDLE;
          end
        end
        stt_pkg::S_IDLE: begin
          unique case (v[0].kind)
            stt_pkg::K_SPACE: cons = 2'd1;
            stt_pkg::K_HASH: begin
              mode_next = stt_pkg::S_LINE;
              run_start_next = vpos;
              run_length_next = 16'd1;
              cons = 2'd1;
            end
            stt_pkg::K_QUOTE: begin
              if (vn >= 2'd2 && v[1].kind != stt_pkg::K_QUOTE) begin
                emit = 1'b1;
                ecls = stt_pkg::CLS_DELIM;
                cons = 2'd1;
              end else if (vn == 2'd3) begin
                if (v[2].kind == stt_pkg::K_QUOTE) begin
                  mode_next = stt_pkg::S_BLOCK;
                  run_start_next = vpos;
                  run_length_next = 16'd3;
                  qrun_next = 2'd0;
                  cons = 2'd3;
                end else begin
                  emit = 1'b1;
                  ecls = stt_pkg::CLS_DELIM;
                  cons = 2'd1;
                end
              end else if (vend) begin
                emit = 1'b1;
                ecls = stt_pkg::CLS_DELIM;
                cons = 2'd1;
              end else begin
                brk = 1'b1;
              end
            end
            stt_pkg::K_ALPHA: begin
              mode_next = stt_pkg::S_WORD;
              run_start_next = vpos;
              run_length_next = 16'd1;
              too_long_next = 1'b0;
              wr_en = 1'b1;
              wr_idx = '0;
              cons = 2'd1;
            end
            stt_pkg::K_DIGIT: begin
              mode_next = stt_pkg::S_NUMBER;
              run_start_next = vpos;
              run_length_next = 16'd1;
              cons = 2'd1;
            end
            stt_pkg::K_PAIR: begin
              if (vn < 2'd2 && !vend) begin
                brk = 1'b1;
              end else if (vn >= 2'd2 && stt_pkg::pairs_with(v[0].ch, v[1].ch)) begin
                emit = 1'b1;
                ecls = stt_pkg::CLS_OPER;
                elen = 16'd2;
                cons = 2'd2;
              end else begin
                emit = 1'b1;
                ecls = (v[0].ch == "&" || v[0].ch == "|") ? stt_pkg::CLS_ERROR
                                                          : stt_pkg::CLS_OPER;
                cons = 2'd1;
              end
            end
            stt_pkg::K_DELIM: begin
              emit = 1'b1;
              ecls = stt_pkg::CLS_DELIM;
              cons = 2'd1;
            end
            default: begin
              emit = 1'b1;
              ecls = stt_pkg::CLS_ERROR;
              cons = 2'd1;
            end
          endcase
        end
        default: cons = 2'd0;
      endcase
    end
  end

  always_comb begin
    unique case (cons)
      2'd0: va = v;
      2'd1: va = '{v[1], v[2], v[2]};
      2'd2: va = '{v[2], v[2], v[2]};
      default: va = v;
    endcase
    vn_after = vn - cons;
    done = brk || (vn_after == 2'd0 && !(vend && mode_next != stt_pkg::S_IDLE));
    go = (active || avail) && !qfull;
    take = go && !active;
    res = hold;
    res_wr = hold_v && (hold.last_of_run || (go && emit)) && !qfull;
  end

  always_ff @(posedge clk) begin
    if (go && wr_en) word[wr_idx] <= wr_data;
    if (go && !done) begin
      w <= va;
      wn <= vn_after;
      wend <= vend;
      wpos <= vpos + P'(cons);
    end
    if (go && done && !vend) begin
      la[0] <= va[0];
      la[1] <= va[1];
    end
    if (go && emit) begin
      hold.token_class <= ecls;
      hold.token_start <= 32'(epos);
      hold.token_length <= elen;
      hold.last_of_run <= done;
    end else if (go && done && hold_v && !res_wr) begin
      hold.last_of_run <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stt_pkg::S_IDLE;
      too_long <= 1'b0;
      run_start <= '0;
      run_length <= 16'd0;
      text_pos <= '0;
      qrun <= 2'd0;
      la_cnt <= 2'd0;
      active <= 1'b0;
      hold_v <= 1'b0;
    end else begin
      if (go && emit) hold_v <= 1'b1;
      else if (res_wr) hold_v <= 1'b0;
      if (go) begin
        active <= !done;
        if (done && vend) begin
          mode <= stt_pkg::S_IDLE;
          too_long <= 1'b0;
          run_start <= '0;
          run_length <= 16'd0;
          text_pos <= '0;
          qrun <= 2'd0;
          la_cnt <= 2'd0;
        end else begin
          mode <= mode_next;
          too_long <= too_long_next;
          run_start <= run_start_next;
          run_length <= run_length_next;
          qrun <= qrun_next;
          if (!active && !vend) text_pos <= text_pos + P'(1);
          if (done) la_cnt <= vn_after;
        end
      end
    end
  end

  a_la_cnt: assert property (@(posedge clk) disable iff (rst) la_cnt != 2'd3)
    else $error("lookahead holds more than two characters");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    go && done && vend |=> text_pos == '0 && mode == stt_pkg::S_IDLE && la_cnt == 2'd0)
    else $error("end of text did not restart the scanner");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    hold_v |-> hold.token_length != 16'd0)
    else $error("token of zero length");
  a_no_lost_hold: assert property (@(posedge clk) disable iff (rst)
    go && emit && hold_v |-> res_wr)
    else $error("held token overwritten before it was queued");
endmodule
